[rtl/core/assert_macros.svh]
// Assertion macros used by the template match search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk_i edge, ignored while rst_ni is low.
`define TMC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Checked on every rising clk_i edge, reset included.
`define TMC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");

`endif

[rtl/core/tmc_pkg.sv]
// Shared constants, codes and types of the template match search block.
`default_nettype none
package tmc_pkg;

  // Store geometry
  localparam int unsigned IMG_MAX_COLS = 128;
  localparam int unsigned IMG_MAX_ROWS = 128;
  localparam int unsigned PAT_MAX_COLS = 32;
  localparam int unsigned PAT_MAX_ROWS = 32;

  localparam int unsigned NUM_CHAN = 3;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned PIX_W    = NUM_CHAN * CHAN_W;

  localparam int unsigned ICOL_W    = $clog2(IMG_MAX_COLS);
  localparam int unsigned IROW_W    = $clog2(IMG_MAX_ROWS);
  localparam int unsigned PCOL_W    = $clog2(PAT_MAX_COLS);
  localparam int unsigned PROW_W    = $clog2(PAT_MAX_ROWS);
  localparam int unsigned IMG_DEPTH = IMG_MAX_COLS * IMG_MAX_ROWS;
  localparam int unsigned PAT_DEPTH = PAT_MAX_COLS * PAT_MAX_ROWS;

  // Request / result field widths
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned OFF_W   = 7;
  localparam int unsigned FRAC_W  = 32;
  localparam int unsigned SCORE_W = FRAC_W + 1;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned SRCH_W     = 8;
  localparam int unsigned PDIM_W     = 6;
  localparam int unsigned ICFG_W     = 8;
  localparam int unsigned OFFSET_LIMIT = 128;

  // Arithmetic widths
  localparam int unsigned CELL_W = $clog2(NUM_CHAN * 255 * 255 + 1);
  localparam int unsigned SUM_W  =
    $clog2(PAT_MAX_COLS * PAT_MAX_ROWS * NUM_CHAN * 255 * 255 + 1);
  localparam int unsigned PROD_W = 2 * SUM_W;
  localparam int unsigned REM_W  = PROD_W + 1;
  localparam int unsigned CNT_W  = $clog2(FRAC_W + 1);

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_PAT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_IMG    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_ROWS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_COLS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_ROWS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_COLS    = 3'd5;

  // Tag that travels with each pixel pair down the cell chain
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } tag_t;

endpackage
`default_nettype wire

[rtl/core/tmc_in_if.sv]
// Request channel: pixel loads and search requests.
`default_nettype none
interface tmc_in_if;
  logic                              valid;
  logic                              ready;
  logic [tmc_pkg::KIND_W-1:0]        kind;
  logic [tmc_pkg::POS_W-1:0]         pix_col;
  logic [tmc_pkg::POS_W-1:0]         pix_row;
  logic [tmc_pkg::CHAN_W-1:0]        chan0;
  logic [tmc_pkg::CHAN_W-1:0]        chan1;
  logic [tmc_pkg::CHAN_W-1:0]        chan2;
  logic [tmc_pkg::SCORE_W-1:0]       start_score;

  modport source (output valid, kind, pix_col, pix_row, chan0, chan1, chan2, start_score,
                  input ready);
  modport sink   (input valid, kind, pix_col, pix_row, chan0, chan1, chan2, start_score,
                  output ready);
endinterface
`default_nettype wire

[rtl/core/tmc_out_if.sv]
// Result channel: best match of one search request.
`default_nettype none
interface tmc_out_if;
  logic                        valid;
  logic                        ready;
  logic [tmc_pkg::OFF_W-1:0]   best_col;
  logic [tmc_pkg::OFF_W-1:0]   best_row;
  logic [tmc_pkg::SCORE_W-1:0] best_score;
  logic                        improved;
  logic                        bad_geometry;

  modport source (output valid, best_col, best_row, best_score, improved, bad_geometry,
                  input ready);
  modport sink   (input valid, best_col, best_row, best_score, improved, bad_geometry,
                  output ready);
endinterface
`default_nettype wire

[rtl/core/tmc_cfg_if.sv]
// Configuration write channel.
`default_nettype none
interface tmc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tmc_pkg::CFG_IDX_W-1:0]  index;
  logic [tmc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/tmc_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module tmc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/core/tmc_cell.sv]
// One channel cell: multiplies its channel byte and adds to the running pixel sums.
`default_nettype none
module tmc_cell (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire tmc_pkg::tag_t                       tag_i,
  input  wire logic [tmc_pkg::NUM_CHAN-1:0]        mask_i,
  input  wire logic [tmc_pkg::PIX_W-1:0]           ipix_i,
  input  wire logic [tmc_pkg::PIX_W-1:0]           ppix_i,
  input  wire logic [tmc_pkg::CELL_W-1:0]          dot_i,
  input  wire logic [tmc_pkg::CELL_W-1:0]          ei_i,
  input  wire logic [tmc_pkg::CELL_W-1:0]          ep_i,
  output tmc_pkg::tag_t                            tag_o,
  output logic      [tmc_pkg::NUM_CHAN-1:0]        mask_o,
  output logic      [tmc_pkg::PIX_W-1:0]           ipix_o,
  output logic      [tmc_pkg::PIX_W-1:0]           ppix_o,
  output logic      [tmc_pkg::CELL_W-1:0]          dot_o,
  output logic      [tmc_pkg::CELL_W-1:0]          ei_o,
  output logic      [tmc_pkg::CELL_W-1:0]          ep_o
);

  localparam int unsigned CW = tmc_pkg::CHAN_W;

  logic [CW-1:0]   a, b;
  logic [2*CW-1:0] ab, aa, bb;
  logic [tmc_pkg::CELL_W-1:0] dot_d, ei_d, ep_d;

  tmc_pkg::tag_t tag_q;
  logic [tmc_pkg::NUM_CHAN-1:0] mask_q;
  logic [tmc_pkg::PIX_W-1:0]    ipix_q, ppix_q;
  logic [tmc_pkg::CELL_W-1:0]   dot_q, ei_q, ep_q;

  // This cell consumes the low byte; the rest shifts down for the next cell
  assign a  = ipix_i[CW-1:0];
  assign b  = ppix_i[CW-1:0];
  assign ab = a * b;
  assign aa = a * a;
  assign bb = b * b;

  always_comb begin
    dot_d = dot_i;
    ei_d  = ei_i;
    ep_d  = ep_i;
    if (mask_i[0]) begin
      dot_d = dot_i + tmc_pkg::CELL_W'(ab);
      ei_d  = ei_i + tmc_pkg::CELL_W'(aa);
      ep_d  = ep_i + tmc_pkg::CELL_W'(bb);
    end
  end

  // Tag register (control)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  // Data registers
  always_ff @(posedge clk_i) begin
    mask_q <= {1'b0, mask_i[tmc_pkg::NUM_CHAN-1:1]};
    ipix_q <= {{CW{1'b0}}, ipix_i[tmc_pkg::PIX_W-1:CW]};
    ppix_q <= {{CW{1'b0}}, ppix_i[tmc_pkg::PIX_W-1:CW]};
    dot_q  <= dot_d;
    ei_q   <= ei_d;
    ep_q   <= ep_d;
  end

  assign tag_o  = tag_q;
  assign mask_o = mask_q;
  assign ipix_o = ipix_q;
  assign ppix_o = ppix_q;
  assign dot_o  = dot_q;
  assign ei_o   = ei_q;
  assign ep_o   = ep_q;

endmodule
`default_nettype wire

[rtl/core/tmc_div.sv]
// Restoring divider: floor(num * 2^32 / den) for num <= den, one quotient bit a cycle.
`default_nettype none
module tmc_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [tmc_pkg::PROD_W-1:0]   num_i,
  input  wire logic [tmc_pkg::PROD_W-1:0]   den_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic      [tmc_pkg::SCORE_W-1:0]  quo_o
);

  localparam int unsigned RW = tmc_pkg::REM_W;

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [tmc_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [RW-1:0]               rem_q, rem_d;
  logic [tmc_pkg::PROD_W-1:0]  den_q, den_d;
  logic [tmc_pkg::SCORE_W-1:0] quo_q, quo_d;
  logic [RW-1:0]               rem_sh, den_ext;
  logic                        ge;

  // First step compares the numerator itself, later steps shift first
  assign rem_sh  = (cnt_q == '0) ? rem_q : {rem_q[RW-2:0], 1'b0};
  assign den_ext = {1'b0, den_q};
  assign ge      = (rem_sh >= den_ext);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = {1'b0, num_i};
      den_d  = den_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - den_ext) : rem_sh;
      quo_d = {quo_q[tmc_pkg::SCORE_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == tmc_pkg::CNT_W'(tmc_pkg::FRAC_W)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

[rtl/core/template_match_cosine_search.sv]
// Template match search. Pixel loads (pattern or image) are taken one per cycle, and are taken
// back to back. A search request walks every offset of the search area, rows outer and
// columns inner; per offset the sequencer streams pat_cols*pat_rows pixel pairs from the
// two stores, one pair a cycle, through a chain of three channel cells into the sum
// accumulators, then squares the dot sum, multiplies the energies and runs a 33-step
// divider; when an energy sum is zero the divider is skipped. A rejected geometry is
// answered without walking any offset. No request is taken while a search runs; a
// waiting result does not block pixel loads. Stores are not cleared.
`default_nettype none
`include "assert_macros.svh"
module template_match_cosine_search (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tmc_in_if.sink     req_i,
  tmc_out_if.source  res_o,
  tmc_cfg_if.sink    cfg_i
);

  localparam int unsigned NCH = tmc_pkg::NUM_CHAN;
  localparam logic [tmc_pkg::SCORE_W-1:0] SCORE_ONE = {1'b1, {tmc_pkg::FRAC_W{1'b0}}};

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ISSUE  = 3'd1;
  localparam logic [2:0] ST_WAIT   = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_DSTART = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_CMP    = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  // Configuration registers
  logic                        color_mode_q;
  logic [tmc_pkg::SRCH_W-1:0]  search_cols_q, search_rows_q;
  logic [tmc_pkg::PDIM_W-1:0]  pat_cols_q, pat_rows_q;
  logic [tmc_pkg::ICFG_W-1:0]  img_cols_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q  <= 1'b0;
      search_cols_q <= tmc_pkg::SRCH_W'(1);
      search_rows_q <= tmc_pkg::SRCH_W'(1);
      pat_cols_q    <= tmc_pkg::PDIM_W'(1);
      pat_rows_q    <= tmc_pkg::PDIM_W'(1);
      img_cols_q    <= tmc_pkg::ICFG_W'(tmc_pkg::IMG_MAX_COLS);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        tmc_pkg::CFG_COLOR_MODE:  color_mode_q  <= cfg_i.data[0];
        tmc_pkg::CFG_SEARCH_COLS: search_cols_q <= cfg_i.data[tmc_pkg::SRCH_W-1:0];
        tmc_pkg::CFG_SEARCH_ROWS: search_rows_q <= cfg_i.data[tmc_pkg::SRCH_W-1:0];
        tmc_pkg::CFG_PAT_COLS:    pat_cols_q    <= cfg_i.data[tmc_pkg::PDIM_W-1:0];
        tmc_pkg::CFG_PAT_ROWS:    pat_rows_q    <= cfg_i.data[tmc_pkg::PDIM_W-1:0];
        tmc_pkg::CFG_IMG_COLS:    img_cols_q    <= cfg_i.data[tmc_pkg::ICFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Geometry check
  logic       bad_geo;
  logic [8:0] col_span, row_span;
  assign col_span = {1'b0, search_cols_q} + 9'(pat_cols_q) - 9'd1;
  assign row_span = {1'b0, search_rows_q} + 9'(pat_rows_q) - 9'd1;
  assign bad_geo  = (search_cols_q == '0) || (search_rows_q == '0) ||
                    (pat_cols_q == '0) || (pat_rows_q == '0) || (img_cols_q == '0) ||
                    (32'(pat_cols_q) > tmc_pkg::PAT_MAX_COLS) ||
                    (32'(pat_rows_q) > tmc_pkg::PAT_MAX_ROWS) ||
                    (32'(img_cols_q) > tmc_pkg::IMG_MAX_COLS) ||
                    (32'(search_cols_q) > tmc_pkg::OFFSET_LIMIT) ||
                    (32'(search_rows_q) > tmc_pkg::OFFSET_LIMIT) ||
                    (col_span > {1'b0, img_cols_q}) ||
                    (32'(row_span) > tmc_pkg::IMG_MAX_ROWS);

  // Sequencer registers
  logic [2:0]                  st_q, st_d;
  logic [tmc_pkg::PCOL_W-1:0]  u_q, u_d;
  logic [tmc_pkg::PROW_W-1:0]  v_q, v_d;
  logic [tmc_pkg::OFF_W-1:0]   ox_q, ox_d, oy_q, oy_d;
  logic [tmc_pkg::OFF_W-1:0]   bx_q, bx_d, by_q, by_d;
  logic [tmc_pkg::SCORE_W-1:0] best_q, best_d;
  logic [tmc_pkg::SCORE_W-1:0] score_q, score_d;
  logic                        imp_q, imp_d, bad_q, bad_d;

  logic req_acc, u_last, v_last, ox_last, oy_last;
  assign req_i.ready = (st_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign u_last  = (pat_cols_q - 1'b1 == tmc_pkg::PDIM_W'(u_q));
  assign v_last  = (pat_rows_q - 1'b1 == tmc_pkg::PDIM_W'(v_q));
  assign ox_last = (search_cols_q - 1'b1 == tmc_pkg::SRCH_W'(ox_q));
  assign oy_last = (search_rows_q - 1'b1 == tmc_pkg::SRCH_W'(oy_q));

  // Stores
  logic                        pat_we, img_we, rd_en;
  logic [tmc_pkg::PIX_W-1:0]   wpix, img_rdata, pat_rdata;
  logic [tmc_pkg::IROW_W-1:0]  img_row;
  logic [tmc_pkg::ICOL_W-1:0]  img_col;

  assign wpix   = {req_i.chan2, req_i.chan1, req_i.chan0};
  assign pat_we = req_acc && (req_i.kind == tmc_pkg::KIND_PAT) &&
                  (32'(req_i.pix_col) < tmc_pkg::PAT_MAX_COLS) &&
                  (32'(req_i.pix_row) < tmc_pkg::PAT_MAX_ROWS);
  assign img_we = req_acc && (req_i.kind == tmc_pkg::KIND_IMG) &&
                  (32'(req_i.pix_col) < tmc_pkg::IMG_MAX_COLS) &&
                  (32'(req_i.pix_row) < tmc_pkg::IMG_MAX_ROWS);
  assign rd_en   = (st_q == ST_ISSUE);
  assign img_row = tmc_pkg::IROW_W'(oy_q) + tmc_pkg::IROW_W'(v_q);
  assign img_col = tmc_pkg::ICOL_W'(ox_q) + tmc_pkg::ICOL_W'(u_q);

  tmc_ram #(
    .Width (tmc_pkg::PIX_W),
    .Depth (tmc_pkg::IMG_DEPTH)
  ) u_img_ram (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .waddr_i ({req_i.pix_row[tmc_pkg::IROW_W-1:0], req_i.pix_col[tmc_pkg::ICOL_W-1:0]}),
    .wdata_i (wpix),
    .re_i    (rd_en),
    .raddr_i ({img_row, img_col}),
    .rdata_o (img_rdata)
  );

  tmc_ram #(
    .Width (tmc_pkg::PIX_W),
    .Depth (tmc_pkg::PAT_DEPTH)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i ({req_i.pix_row[tmc_pkg::PROW_W-1:0], req_i.pix_col[tmc_pkg::PCOL_W-1:0]}),
    .wdata_i (wpix),
    .re_i    (rd_en),
    .raddr_i ({v_q, u_q}),
    .rdata_o (pat_rdata)
  );

  // Tag that lines up with the registered read data
  tmc_pkg::tag_t rd_tag_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_tag_q <= '0;
    end else begin
      rd_tag_q.vld   <= rd_en;
      rd_tag_q.first <= (u_q == '0) && (v_q == '0);
      rd_tag_q.last  <= u_last && v_last;
    end
  end

  // Cell chain, one cell per channel
  tmc_pkg::tag_t               chain_tag  [NCH+1];
  logic [NCH-1:0]              chain_mask [NCH+1];
  logic [tmc_pkg::PIX_W-1:0]   chain_ipix [NCH+1];
  logic [tmc_pkg::PIX_W-1:0]   chain_ppix [NCH+1];
  logic [tmc_pkg::CELL_W-1:0]  chain_dot  [NCH+1];
  logic [tmc_pkg::CELL_W-1:0]  chain_ei   [NCH+1];
  logic [tmc_pkg::CELL_W-1:0]  chain_ep   [NCH+1];

  assign chain_tag[0]  = rd_tag_q;
  assign chain_mask[0] = color_mode_q ? {NCH{1'b1}} : NCH'(1);
  assign chain_ipix[0] = img_rdata;
  assign chain_ppix[0] = pat_rdata;
  assign chain_dot[0]  = '0;
  assign chain_ei[0]   = '0;
  assign chain_ep[0]   = '0;

  for (genvar k = 0; k < NCH; k++) begin : g_cell
    tmc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tag_i  (chain_tag[k]),
      .mask_i (chain_mask[k]),
      .ipix_i (chain_ipix[k]),
      .ppix_i (chain_ppix[k]),
      .dot_i  (chain_dot[k]),
      .ei_i   (chain_ei[k]),
      .ep_i   (chain_ep[k]),
      .tag_o  (chain_tag[k+1]),
      .mask_o (chain_mask[k+1]),
      .ipix_o (chain_ipix[k+1]),
      .ppix_o (chain_ppix[k+1]),
      .dot_o  (chain_dot[k+1]),
      .ei_o   (chain_ei[k+1]),
      .ep_o   (chain_ep[k+1])
    );
  end

  // Offset sums
  logic [tmc_pkg::SUM_W-1:0] acc_dot_q, acc_ei_q, acc_ep_q;
  logic                      acc_done_q;
  tmc_pkg::tag_t             tail_tag;
  assign tail_tag = chain_tag[NCH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_done_q <= 1'b0;
    end else begin
      acc_done_q <= tail_tag.vld && tail_tag.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail_tag.vld) begin
      if (tail_tag.first) begin
        acc_dot_q <= tmc_pkg::SUM_W'(chain_dot[NCH]);
        acc_ei_q  <= tmc_pkg::SUM_W'(chain_ei[NCH]);
        acc_ep_q  <= tmc_pkg::SUM_W'(chain_ep[NCH]);
      end else begin
        acc_dot_q <= acc_dot_q + tmc_pkg::SUM_W'(chain_dot[NCH]);
        acc_ei_q  <= acc_ei_q + tmc_pkg::SUM_W'(chain_ei[NCH]);
        acc_ep_q  <= acc_ep_q + tmc_pkg::SUM_W'(chain_ep[NCH]);
      end
    end
  end

  // Square and energy product
  logic [tmc_pkg::PROD_W-1:0] num_q, den_q;
  logic                       zero_q;
  always_ff @(posedge clk_i) begin
    if (st_q == ST_MUL) begin
      num_q  <= acc_dot_q * acc_dot_q;
      den_q  <= acc_ei_q * acc_ep_q;
      zero_q <= (acc_ei_q == '0) || (acc_ep_q == '0);
    end
  end

  // Divider
  logic                        div_start, div_busy, div_done;
  logic [tmc_pkg::SCORE_W-1:0] div_quo;
  assign div_start = (st_q == ST_DSTART) && !zero_q;

  tmc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Output register
  logic                        out_vld_q, out_vld_d, out_load;
  logic [tmc_pkg::OFF_W-1:0]   out_col_q, out_row_q;
  logic [tmc_pkg::SCORE_W-1:0] out_score_q;
  logic                        out_imp_q, out_bad_q;

  assign out_load  = (st_q == ST_FINISH) && (!out_vld_q || res_o.ready);
  assign out_vld_d = out_load ? 1'b1 : (out_vld_q && !res_o.ready);

  // Sequencer next state
  always_comb begin
    st_d    = st_q;
    u_d     = u_q;
    v_d     = v_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    bx_d    = bx_q;
    by_d    = by_q;
    best_d  = best_q;
    score_d = score_q;
    imp_d   = imp_q;
    bad_d   = bad_q;
    case (st_q)
      ST_IDLE: begin
        if (req_acc && (req_i.kind == tmc_pkg::KIND_SEARCH)) begin
          best_d = req_i.start_score;
          bx_d   = '0;
          by_d   = '0;
          imp_d  = 1'b0;
          bad_d  = bad_geo;
          ox_d   = '0;
          oy_d   = '0;
          u_d    = '0;
          v_d    = '0;
          st_d   = bad_geo ? ST_FINISH : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (u_last) begin
          u_d = '0;
          if (v_last) begin
            v_d  = '0;
            st_d = ST_WAIT;
          end else begin
            v_d = v_q + 1'b1;
          end
        end else begin
          u_d = u_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (acc_done_q) begin
          st_d = ST_MUL;
        end
      end
      ST_MUL: begin
        st_d = ST_DSTART;
      end
      ST_DSTART: begin
        if (zero_q) begin
          score_d = SCORE_ONE;
          st_d    = ST_CMP;
        end else begin
          st_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          score_d = div_quo;
          st_d    = ST_CMP;
        end
      end
      ST_CMP: begin
        if (score_q > best_q) begin
          best_d = score_q;
          bx_d   = ox_q;
          by_d   = oy_q;
          imp_d  = 1'b1;
        end
        st_d = ST_ISSUE;
        if (ox_last) begin
          ox_d = '0;
          if (oy_last) begin
            st_d = ST_FINISH;
          end else begin
            oy_d = oy_q + 1'b1;
          end
        end else begin
          ox_d = ox_q + 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      u_q       <= '0;
      v_q       <= '0;
      ox_q      <= '0;
      oy_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      u_q       <= u_d;
      v_q       <= v_d;
      ox_q      <= ox_d;
      oy_q      <= oy_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bx_q    <= bx_d;
    by_q    <= by_d;
    best_q  <= best_d;
    score_q <= score_d;
    imp_q   <= imp_d;
    bad_q   <= bad_d;
    if (out_load) begin
      out_col_q   <= bx_q;
      out_row_q   <= by_q;
      out_score_q <= best_q;
      out_imp_q   <= imp_q;
      out_bad_q   <= bad_q;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.best_col     = out_col_q;
  assign res_o.best_row     = out_row_q;
  assign res_o.best_score   = out_score_q;
  assign res_o.improved     = out_imp_q;
  assign res_o.bad_geometry = out_bad_q;

  // Checks
  `TMC_ASSERT(a_div_only_in_div, div_busy |-> (st_q == ST_DIV))
  `TMC_ASSERT(a_bad_no_improve, (res_o.valid && res_o.bad_geometry) |-> !res_o.improved)
  `TMC_ASSERT(a_no_improve_zero_pos,
              (res_o.valid && !res_o.improved) |->
              ((res_o.best_col == '0) && (res_o.best_row == '0)))
  `TMC_ASSERT_ALWAYS(a_chain_empty_idle, (st_q == ST_IDLE) |-> !tail_tag.vld)

endmodule
`default_nettype wire

[tb/tb_template_match_cosine_search.sv]
// Self-checking testbench for the template match cosine search block.
`default_nettype none
module tb_template_match_cosine_search;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [tmc_pkg::KIND_W-1:0] KIND_NONE = 2'd3;
  localparam longint unsigned ONE_Q32 = 64'h1_0000_0000;
  localparam int RAND_ITEMS = 80;
  localparam int QUIET_AT = 60;
  localparam int SETTLE = 64;

  typedef struct {
    logic [tmc_pkg::KIND_W-1:0]  kind;
    logic [tmc_pkg::POS_W-1:0]   col;
    logic [tmc_pkg::POS_W-1:0]   row;
    logic [tmc_pkg::CHAN_W-1:0]  c0;
    logic [tmc_pkg::CHAN_W-1:0]  c1;
    logic [tmc_pkg::CHAN_W-1:0]  c2;
    logic [tmc_pkg::SCORE_W-1:0] seed;
  } pix_req_t;

  typedef struct {
    logic [tmc_pkg::OFF_W-1:0]   bcol;
    logic [tmc_pkg::OFF_W-1:0]   brow;
    logic [tmc_pkg::SCORE_W-1:0] score;
    logic                        imp;
    logic                        bad;
  } match_t;

  logic clk_i;
  logic rst_ni;

  tmc_in_if  req_if ();
  tmc_out_if res_if ();
  tmc_cfg_if cfg_if ();

  template_match_cosine_search DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  // Shadow stores and registers
  logic [tmc_pkg::PIX_W-1:0] img_mem [tmc_pkg::IMG_DEPTH];
  logic [tmc_pkg::PIX_W-1:0] pat_mem [tmc_pkg::PAT_DEPTH];
  bit img_plan [tmc_pkg::IMG_DEPTH];
  bit pat_plan [tmc_pkg::PAT_DEPTH];
  int cfg_cm = 0, cfg_sc = 1, cfg_sr = 1, cfg_pc = 1, cfg_pr = 1, cfg_ic = 128;

  pix_req_t req_backlog [$];
  match_t   best_match_q [$];
  pix_req_t cur_req;
  int  gap_left;
  int  stall_left;
  bit  quiet = 0;
  int  errors = 0;
  int  issued = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic bit geom_bad();
    return cfg_sc == 0 || cfg_sr == 0 || cfg_pc == 0 || cfg_pr == 0 || cfg_ic == 0 ||
           cfg_pc > tmc_pkg::PAT_MAX_COLS || cfg_pr > tmc_pkg::PAT_MAX_ROWS ||
           cfg_ic > tmc_pkg::IMG_MAX_COLS ||
           cfg_sc > tmc_pkg::OFFSET_LIMIT || cfg_sr > tmc_pkg::OFFSET_LIMIT ||
           cfg_sc + cfg_pc - 1 > cfg_ic || cfg_sr + cfg_pr - 1 > tmc_pkg::IMG_MAX_ROWS;
  endfunction

  // floor(num * 2^32 / den), restoring division
  function automatic longint unsigned q32_div(longint unsigned num, longint unsigned den);
    longint unsigned q, r;
    q = 0;
    r = num;
    if (r >= den) begin
      q = 1;
      r -= den;
    end
    for (int i = 0; i < tmc_pkg::FRAC_W; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned offset_score(int ox, int oy);
    longint unsigned dot, ei, ep, a, b;
    logic [tmc_pkg::PIX_W-1:0] ip, pp;
    int nch;
    dot = 0;
    ei = 0;
    ep = 0;
    nch = cfg_cm ? 3 : 1;
    for (int v = 0; v < cfg_pr; v++) begin
      for (int u = 0; u < cfg_pc; u++) begin
        ip = img_mem[(oy + v) * tmc_pkg::IMG_MAX_COLS + ox + u];
        pp = pat_mem[v * tmc_pkg::PAT_MAX_COLS + u];
        for (int c = 0; c < nch; c++) begin
          a = 64'(ip[8*c +: 8]);
          b = 64'(pp[8*c +: 8]);
          dot += a * b;
          ei += a * a;
          ep += b * b;
        end
      end
    end
    if (ei == 0 || ep == 0) return ONE_Q32;
    return q32_div(dot * dot, ei * ep);
  endfunction

  function automatic match_t predict_best_match(logic [tmc_pkg::SCORE_W-1:0] seed);
    match_t m;
    longint unsigned best, s;
    m.bcol = '0;
    m.brow = '0;
    m.imp = 1'b0;
    m.bad = geom_bad();
    best = 64'(seed);
    if (!m.bad) begin
      for (int y = 0; y < cfg_sr; y++) begin
        for (int x = 0; x < cfg_sc; x++) begin
          s = offset_score(x, y);
          if (s > best) begin
            best = s;
            m.bcol = tmc_pkg::OFF_W'(x);
            m.brow = tmc_pkg::OFF_W'(y);
            m.imp = 1'b1;
          end
        end
      end
    end
    m.score = best[tmc_pkg::SCORE_W-1:0];
    return m;
  endfunction

  // Apply an accepted request to the shadow state
  function automatic void absorb_req(pix_req_t r);
    case (r.kind)
      tmc_pkg::KIND_PAT: begin
        if (r.col < tmc_pkg::PAT_MAX_COLS && r.row < tmc_pkg::PAT_MAX_ROWS)
          pat_mem[r.row * tmc_pkg::PAT_MAX_COLS + r.col] = {r.c2, r.c1, r.c0};
      end
      tmc_pkg::KIND_IMG: begin
        img_mem[r.row * tmc_pkg::IMG_MAX_COLS + r.col] = {r.c2, r.c1, r.c0};
      end
      tmc_pkg::KIND_SEARCH: best_match_q.push_back(predict_best_match(r.seed));
      default: ;
    endcase
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    bit holding;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.kind <= '0;
      req_if.pix_col <= '0;
      req_if.pix_row <= '0;
      req_if.chan0 <= '0;
      req_if.chan1 <= '0;
      req_if.chan2 <= '0;
      req_if.start_score <= '0;
      gap_left = 0;
    end else begin
      if (req_if.valid && req_if.ready) absorb_req(cur_req);
      holding = req_if.valid && !req_if.ready;
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(1, 14) - 1;
          req_if.valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          cur_req = req_backlog.pop_front();
          req_if.kind <= cur_req.kind;
          req_if.pix_col <= cur_req.col;
          req_if.pix_row <= cur_req.row;
          req_if.chan0 <= cur_req.c0;
          req_if.chan1 <= cur_req.c1;
          req_if.chan2 <= cur_req.c2;
          req_if.start_score <= cur_req.seed;
          req_if.valid <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result ready with random stall bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic chk_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, exp_v, act_v);
    end
  endtask

  // Result monitor
  always @(posedge clk_i) begin
    match_t m;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (best_match_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual score %0d",
                 $realtime, res_if.best_score);
      end else begin
        m = best_match_q.pop_front();
        chk_field("best_col", m.bcol, res_if.best_col);
        chk_field("best_row", m.brow, res_if.best_row);
        chk_field("best_score", m.score, res_if.best_score);
        chk_field("improved", m.imp, res_if.improved);
        chk_field("bad_geometry", m.bad, res_if.bad_geometry);
      end
    end
  end

  task automatic cfg_write(logic [tmc_pkg::CFG_IDX_W-1:0] idx, int val);
    cfg_if.index <= idx;
    cfg_if.data <= val[tmc_pkg::CFG_DATA_W-1:0];
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      tmc_pkg::CFG_COLOR_MODE:  cfg_cm = val & 1;
      tmc_pkg::CFG_SEARCH_COLS: cfg_sc = val & 8'hFF;
      tmc_pkg::CFG_SEARCH_ROWS: cfg_sr = val & 8'hFF;
      tmc_pkg::CFG_PAT_COLS:    cfg_pc = val & 6'h3F;
      tmc_pkg::CFG_PAT_ROWS:    cfg_pr = val & 6'h3F;
      tmc_pkg::CFG_IMG_COLS:    cfg_ic = val & 8'hFF;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic cfg_all(int cm, int sc, int sr, int pc, int pr, int ic);
    cfg_write(tmc_pkg::CFG_COLOR_MODE, cm);
    cfg_write(tmc_pkg::CFG_SEARCH_COLS, sc);
    cfg_write(tmc_pkg::CFG_SEARCH_ROWS, sr);
    cfg_write(tmc_pkg::CFG_PAT_COLS, pc);
    cfg_write(tmc_pkg::CFG_PAT_ROWS, pr);
    cfg_write(tmc_pkg::CFG_IMG_COLS, ic);
  endtask

  // Block is idle: nothing queued, nothing pending, then settle
  task automatic wait_idle();
    do @(posedge clk_i);
    while (req_backlog.size() != 0 || req_if.valid || best_match_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic push_req(logic [tmc_pkg::KIND_W-1:0] kind, int col, int row,
                          int c0 = -1, int c1 = -1, int c2 = -1);
    pix_req_t r;
    r.kind = kind;
    r.col = tmc_pkg::POS_W'(col);
    r.row = tmc_pkg::POS_W'(row);
    r.c0 = tmc_pkg::CHAN_W'((c0 < 0) ? $urandom_range(0, 255) : c0);
    r.c1 = tmc_pkg::CHAN_W'((c1 < 0) ? $urandom_range(0, 255) : c1);
    r.c2 = tmc_pkg::CHAN_W'((c2 < 0) ? $urandom_range(0, 255) : c2);
    r.seed = tmc_pkg::SCORE_W'({$urandom_range(0, 1), $urandom});
    if (kind == tmc_pkg::KIND_PAT && col < tmc_pkg::PAT_MAX_COLS &&
        row < tmc_pkg::PAT_MAX_ROWS) begin
      pat_plan[row * tmc_pkg::PAT_MAX_COLS + col] = 1;
      issued++;
    end else if (kind == tmc_pkg::KIND_IMG) begin
      img_plan[row * tmc_pkg::IMG_MAX_COLS + col] = 1;
      issued++;
    end
    req_backlog.push_back(r);
  endtask

  task automatic push_search(logic [tmc_pkg::SCORE_W-1:0] seed);
    pix_req_t r;
    r.kind = tmc_pkg::KIND_SEARCH;
    r.col = tmc_pkg::POS_W'($urandom_range(0, 127));
    r.row = tmc_pkg::POS_W'($urandom_range(0, 127));
    r.c0 = tmc_pkg::CHAN_W'($urandom_range(0, 255));
    r.c1 = tmc_pkg::CHAN_W'($urandom_range(0, 255));
    r.c2 = tmc_pkg::CHAN_W'($urandom_range(0, 255));
    r.seed = seed;
    issued++;
    req_backlog.push_back(r);
  endtask

  // Load every pixel a good search will read that is not yet loaded
  task automatic cover_region();
    if (!geom_bad()) begin
      for (int v = 0; v < cfg_pr; v++)
        for (int u = 0; u < cfg_pc; u++)
          if (!pat_plan[v * tmc_pkg::PAT_MAX_COLS + u]) push_req(tmc_pkg::KIND_PAT, u, v);
      for (int y = 0; y < cfg_sr + cfg_pr - 1; y++)
        for (int x = 0; x < cfg_sc + cfg_pc - 1; x++)
          if (!img_plan[y * tmc_pkg::IMG_MAX_COLS + x]) push_req(tmc_pkg::KIND_IMG, x, y);
    end
  endtask

  function automatic logic [tmc_pkg::SCORE_W-1:0] pick_seed();
    case ($urandom_range(0, 5))
      0, 1, 2: return '0;
      3: return ONE_Q32[tmc_pkg::SCORE_W-1:0];
      default: return tmc_pkg::SCORE_W'({$urandom_range(0, 1), $urandom});
    endcase
  endfunction

  task automatic directed_phase(int cm, int sc, int sr, int pc, int pr, int ic);
    cfg_all(cm, sc, sr, pc, pr, ic);
    cover_region();
    push_search('0);
    push_search(pick_seed());
    wait_idle();
  endtask

  task automatic random_phase();
    int n_srch, n_load, sel;
    if ($urandom_range(0, 7) == 0) begin
      cfg_all($urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255));
      if (!geom_bad()) cfg_write(tmc_pkg::CFG_PAT_COLS, 0);
    end else begin
      sel = $urandom_range(1, 4);
      n_load = $urandom_range(1, 4);
      cfg_all($urandom_range(0, 1), sel, $urandom_range(1, 4), n_load,
              $urandom_range(1, 4), $urandom_range(sel + n_load - 1, 128));
    end
    n_srch = $urandom_range(1, 3);
    for (int s = 0; s < n_srch; s++) begin
      cover_region();
      n_load = $urandom_range(2, 12);
      for (int i = 0; i < n_load; i++) begin
        sel = $urandom_range(0, 9);
        if (sel == 0)
          // noise: unused kind or loads that may fall outside the pattern store
          push_req(($urandom_range(0, 1) ? KIND_NONE : tmc_pkg::KIND_PAT),
                   $urandom_range(0, 127), $urandom_range(0, 127));
        else if (geom_bad())
          push_req(tmc_pkg::KIND_IMG, $urandom_range(0, 127), $urandom_range(0, 127));
        else if (sel < 4)
          push_req(tmc_pkg::KIND_PAT, $urandom_range(0, cfg_pc - 1),
                   $urandom_range(0, cfg_pr - 1));
        else
          push_req(tmc_pkg::KIND_IMG, $urandom_range(0, cfg_sc + cfg_pc - 2),
                   $urandom_range(0, cfg_sr + cfg_pr - 2));
      end
      push_search(pick_seed());
    end
    wait_idle();
  endtask

  // Stimulus sequence
  initial begin
    int base;
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (3) @(posedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Reset config: zero energy, seed extremes, ignored loads, unused kind
    push_req(tmc_pkg::KIND_PAT, 0, 0, 0, 0, 0);
    push_req(tmc_pkg::KIND_IMG, 0, 0, 0, 0, 0);
    push_req(tmc_pkg::KIND_PAT, 127, 127);
    push_req(tmc_pkg::KIND_PAT, 31, 100);
    push_req(KIND_NONE, 0, 0);
    push_search('0);
    push_search(ONE_Q32[tmc_pkg::SCORE_W-1:0]);
    push_search('1);
    push_req(tmc_pkg::KIND_PAT, 0, 0, 255, 255, 255);
    push_req(tmc_pkg::KIND_IMG, 0, 0, 255, 255, 255);
    push_search('0);
    push_req(tmc_pkg::KIND_IMG, 127, 127, 255, 255, 255);
    wait_idle();

    // Register extremes and each bad geometry case
    directed_phase(1, 128, 1, 1, 1, 128);
    directed_phase(0, 1, 128, 1, 1, 1);
    directed_phase(1, 1, 1, 32, 1, 32);
    directed_phase(0, 1, 1, 1, 32, 128);
    directed_phase(1, 97, 1, 32, 1, 128);
    directed_phase(0, 0, 1, 1, 1, 128);
    directed_phase(0, 200, 1, 1, 1, 128);
    directed_phase(0, 1, 0, 1, 1, 128);
    directed_phase(0, 129, 1, 1, 1, 128);
    directed_phase(0, 1, 129, 1, 1, 128);
    directed_phase(0, 1, 128, 1, 2, 128);
    directed_phase(0, 1, 1, 0, 1, 128);
    directed_phase(0, 1, 1, 40, 1, 128);
    directed_phase(0, 1, 1, 1, 33, 128);
    directed_phase(0, 1, 1, 1, 0, 128);
    directed_phase(0, 1, 1, 1, 1, 0);
    directed_phase(0, 1, 1, 1, 1, 200);
    directed_phase(1, 5, 1, 4, 1, 7);

    // Random phases, quiet handshakes toward the end
    base = issued;
    while (issued - base < RAND_ITEMS) begin
      if (issued - base > QUIET_AT) quiet = 1;
      random_phase();
    end

    wait_idle();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
